// ===== rtl/cfp_pkg.sv =====
// Package for the capability frame parser.
// Holds position sizing, frame constants, status and outcome codes, and the level picker.
// Used by capability_frame_parser_core.
package cfp_pkg;

  localparam int POSITION_WIDTH = 16;

  localparam logic [7:0] HEADER_BYTE    = 8'h01;
  localparam logic [7:0] TECH_SOUNDING  = 8'h01;
  localparam int         TECH_BIT       = 1;
  localparam logic [7:0] MIN_BLOCK_SIZE = 8'd2;
  localparam logic [7:0] MIN_CS_SIZE    = 8'd9;
  localparam logic [16:0] FIRST_BLOCK   = 17'd4;
  localparam logic [2:0] NO_LEVEL       = 3'd7;
  localparam int         TOP_LEVEL      = 4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_NOTSUP   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;

  typedef enum logic [2:0] {
    OUT_PENDING = 3'd0,
    OUT_OK      = 3'd1,
    OUT_BAD     = 3'd2,
    OUT_NOTSUP  = 3'd3
  } outcome_t;

  function automatic logic [2:0] highest_level(input logic [7:0] mask);
    logic [2:0] lv;
    lv = NO_LEVEL;
    for (int i = 0; i <= TOP_LEVEL; i++) begin
      if (mask[i]) lv = 3'(i);
    end
    return lv;
  endfunction

endpackage

// ===== rtl/capability_frame_parser_core.sv =====
// Capability frame parser: byte-wise walk of one capability response frame.
// Result path: the final byte passes from the input register into the result register, where it is held while stalled.
// Throughput: one byte per cycle; a final byte waits only while a held result is stalled.
// Reset (rst, synchronous, active high) clears both registers' valid and all parse state.
// After each final byte the parse state returns to its reset value.
// Depends on cfp_pkg.
module capability_frame_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [2:0] security_level
);

  localparam int PW = cfp_pkg::POSITION_WIDTH;
  localparam logic [PW-1:0] POS_MAX = '1;

  logic            iv;
  logic [7:0]      in_b;
  logic            in_last;

  logic [PW-1:0]   byte_position, byte_position_next;
  logic            header_ok, header_ok_next;
  logic            technology_ok, technology_ok_next;
  logic [16:0]     next_block_start, next_block_start_next;
  logic [16:0]     block_end, block_end_next;
  logic            block_is_sounding, block_is_sounding_next;
  logic [2:0]      candidate_level, candidate_level_next;
  cfp_pkg::outcome_t outcome, outcome_next;

  logic            out_free, proc, accept, emit;
  logic [17:0]     p18, nbs18;
  logic [PW-1:0]   len;
  logic [2:0]      status_next, level_next;
  logic            final_chk;

  assign out_free = !out_valid || !out_stall;
  assign proc     = iv && (!in_last || out_free);
  assign in_stall = iv && !proc;
  assign accept   = in_valid && !in_stall;
  assign emit     = proc && in_last;

  always_comb begin
    byte_position_next     = byte_position;
    header_ok_next         = header_ok;
    technology_ok_next     = technology_ok;
    next_block_start_next  = next_block_start;
    block_end_next         = block_end;
    block_is_sounding_next = block_is_sounding;
    candidate_level_next   = candidate_level;
    outcome_next           = outcome;
    p18                    = 18'(byte_position);
    nbs18                  = 18'(next_block_start);
    final_chk              = 1'b0;
    len                    = byte_position;
    status_next            = cfp_pkg::ST_NOTFOUND;
    level_next             = 3'd0;

    if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + 1'b1;
      len                = byte_position + 1'b1;
      if (outcome == cfp_pkg::OUT_PENDING && header_ok) begin
        if (p18 <= 18'd1) begin
          if (in_b != cfp_pkg::HEADER_BYTE) header_ok_next = 1'b0;
        end else if (p18 == 18'd2) begin
          technology_ok_next = in_b[cfp_pkg::TECH_BIT];
        end else if (p18 == 18'd3) begin
          if (!technology_ok) outcome_next = cfp_pkg::OUT_NOTSUP;
        end else if (p18 == nbs18) begin
          block_is_sounding_next = (in_b == cfp_pkg::TECH_SOUNDING);
          block_end_next         = next_block_start;
        end else if (p18 == nbs18 + 18'd1) begin
          block_end_next = 17'(nbs18 + 18'(in_b));
          if (in_b < cfp_pkg::MIN_BLOCK_SIZE ||
              (block_is_sounding && in_b < cfp_pkg::MIN_CS_SIZE)) begin
            outcome_next = cfp_pkg::OUT_BAD;
          end else if (!block_is_sounding) begin
            next_block_start_next = 17'(nbs18 + 18'(in_b));
          end
        end else begin
          if (block_is_sounding && p18 == nbs18 + 18'd2) begin
            candidate_level_next = cfp_pkg::highest_level(in_b);
          end
          final_chk = block_is_sounding && p18 >= nbs18 + 18'd2 &&
                      (p18 + 18'd1) == 18'(block_end);
        end
        if (final_chk) begin
          outcome_next = (candidate_level_next == cfp_pkg::NO_LEVEL) ?
                         cfp_pkg::OUT_NOTSUP : cfp_pkg::OUT_OK;
        end
      end
    end

    case (outcome_next)
      cfp_pkg::OUT_OK: begin
        status_next = cfp_pkg::ST_OK;
        level_next  = candidate_level_next;
      end
      cfp_pkg::OUT_BAD:    status_next = cfp_pkg::ST_BAD;
      cfp_pkg::OUT_NOTSUP: status_next = cfp_pkg::ST_NOTSUP;
      default: begin
        if (!header_ok_next || len < PW'(2)) begin
          status_next = cfp_pkg::ST_IGNORED;
        end else if (len < PW'(4) || 17'(len) < block_end_next) begin
          status_next = cfp_pkg::ST_BAD;
        end else begin
          status_next = cfp_pkg::ST_NOTFOUND;
        end
      end
    endcase

    if (in_last) begin
      byte_position_next     = '0;
      header_ok_next         = 1'b1;
      technology_ok_next     = 1'b0;
      next_block_start_next  = cfp_pkg::FIRST_BLOCK;
      block_end_next         = '0;
      block_is_sounding_next = 1'b0;
      candidate_level_next   = cfp_pkg::NO_LEVEL;
      outcome_next           = cfp_pkg::OUT_PENDING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv                <= 1'b0;
      out_valid         <= 1'b0;
      byte_position     <= '0;
      header_ok         <= 1'b1;
      technology_ok     <= 1'b0;
      next_block_start  <= cfp_pkg::FIRST_BLOCK;
      block_end         <= '0;
      block_is_sounding <= 1'b0;
      candidate_level   <= cfp_pkg::NO_LEVEL;
      outcome           <= cfp_pkg::OUT_PENDING;
    end else begin
      if (accept) begin
        iv <= 1'b1;
      end else if (proc) begin
        iv <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (proc) begin
        byte_position     <= byte_position_next;
        header_ok         <= header_ok_next;
        technology_ok     <= technology_ok_next;
        next_block_start  <= next_block_start_next;
        block_end         <= block_end_next;
        block_is_sounding <= block_is_sounding_next;
        candidate_level   <= candidate_level_next;
        outcome           <= outcome_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_b    <= data_byte;
      in_last <= last_byte;
    end
    if (emit) begin
      status         <= status_next;
      security_level <= level_next;
    end
  end

endmodule

// ===== dv/tb_capability_frame_parser_core.sv =====
// Self-checking testbench for capability_frame_parser_core: directed and random frames.
// Predicts the status and level of each frame and checks every result in order.
// Depends on cfp_pkg and the RTL of the parser core.
module tb_capability_frame_parser_core;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 28;
  localparam int DRAIN_CYCLES = 10;
  localparam int unsigned POS_MAX = (1 << cfp_pkg::POSITION_WIDTH) - 1;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] level;
  } verdict_t;

  typedef logic [7:0] frame_bytes_t[$];

  class frame_scoreboard;
    logic [cfp_pkg::POSITION_WIDTH-1:0] frame_pos;
    bit header_match;
    bit tech_ok;
    logic [16:0] block_start;
    logic [16:0] block_end;
    bit in_sounding;
    logic [2:0] best_level;
    cfp_pkg::outcome_t verdict;
    verdict_t expected_q[$];
    int errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      frame_pos = '0;
      header_match = 1'b1;
      tech_ok = 1'b0;
      block_start = cfp_pkg::FIRST_BLOCK;
      block_end = '0;
      in_sounding = 1'b0;
      best_level = cfp_pkg::NO_LEVEL;
      verdict = cfp_pkg::OUT_PENDING;
    endfunction

    function logic [2:0] top_level(logic [7:0] mask);
      for (int lv = cfp_pkg::TOP_LEVEL; lv >= 0; lv--) begin
        if (mask[lv]) return 3'(lv);
      end
      return cfp_pkg::NO_LEVEL;
    endfunction

    function void parse_byte(int unsigned p, logic [7:0] b);
      if (p <= 1) begin
        if (b != cfp_pkg::HEADER_BYTE) header_match = 1'b0;
        return;
      end
      if (p == 2) begin
        tech_ok = b[cfp_pkg::TECH_BIT];
        return;
      end
      if (p == 3) begin
        if (!tech_ok) verdict = cfp_pkg::OUT_NOTSUP;
        return;
      end
      if (p == block_start) begin
        in_sounding = (b == cfp_pkg::TECH_SOUNDING);
        block_end = block_start;
      end else if (p == block_start + 1) begin
        block_end = block_start + b;
        if (b < cfp_pkg::MIN_BLOCK_SIZE || (in_sounding && b < cfp_pkg::MIN_CS_SIZE)) begin
          verdict = cfp_pkg::OUT_BAD;
          return;
        end
        if (!in_sounding) block_start = block_end;
      end else if (in_sounding && p == block_start + 2) begin
        best_level = top_level(b);
      end
      if (in_sounding && p >= block_start + 2 && p + 1 == block_end)
        verdict = (best_level == cfp_pkg::NO_LEVEL) ? cfp_pkg::OUT_NOTSUP : cfp_pkg::OUT_OK;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned p;
      int unsigned len;
      verdict_t v;
      p = frame_pos;
      if (p < POS_MAX) begin
        if (verdict == cfp_pkg::OUT_PENDING && header_match) parse_byte(p, b);
        frame_pos = frame_pos + 1'b1;
        len = p + 1;
      end else begin
        len = POS_MAX;
      end
      if (!last) return;
      v.level = '0;
      case (verdict)
        cfp_pkg::OUT_OK: begin
          v.status = cfp_pkg::ST_OK;
          v.level = best_level;
        end
        cfp_pkg::OUT_BAD: v.status = cfp_pkg::ST_BAD;
        cfp_pkg::OUT_NOTSUP: v.status = cfp_pkg::ST_NOTSUP;
        default: begin
          if (!header_match || len < 2) v.status = cfp_pkg::ST_IGNORED;
          else if (len < cfp_pkg::FIRST_BLOCK || len < block_end) v.status = cfp_pkg::ST_BAD;
          else v.status = cfp_pkg::ST_NOTFOUND;
        end
      endcase
      expected_q.push_back(v);
      clear_frame();
    endfunction

    function void check_result(logic [2:0] st, logic [2:0] lv);
      verdict_t v;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d level %0d",
                 $time, st, lv);
        errors++;
        return;
      end
      v = expected_q.pop_front();
      if (st !== v.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, v.status, st);
        errors++;
      end
      if (lv !== v.level) begin
        $display("%0t: level mismatch: expected %0d, actual %0d", $time, v.level, lv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic last_byte = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [2:0] status;
  logic [2:0] security_level;

  frame_scoreboard sb = new();
  frame_bytes_t frame;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int items_counted = 0;

  capability_frame_parser_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .security_level(security_level)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, last);
  endtask

  task automatic send_frame();
    items_counted += frame.size();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: return 8'(1 << $urandom_range(cfp_pkg::TOP_LEVEL));
      2: return 8'($urandom_range(255)) & 8'he0;
      default: return 8'($urandom_range(255)) | 8'(1 << $urandom_range(cfp_pkg::TOP_LEVEL));
    endcase
  endfunction

  function automatic void push_block(logic [7:0] tech, logic [7:0] size, logic [7:0] first_body);
    frame.push_back(tech);
    frame.push_back(size);
    for (int i = 2; i < size; i++) frame.push_back((i == 2) ? first_body : 8'($urandom_range(255)));
  endfunction

  function automatic void build_good(bit with_sounding);
    logic [7:0] tech_lo;
    logic [7:0] t;
    frame = {};
    frame.push_back(cfp_pkg::HEADER_BYTE);
    frame.push_back(cfp_pkg::HEADER_BYTE);
    tech_lo = 8'($urandom_range(255));
    tech_lo[cfp_pkg::TECH_BIT] = 1'b1;
    frame.push_back(tech_lo);
    frame.push_back(8'($urandom_range(255)));
    repeat ($urandom_range(3)) begin
      t = 8'($urandom_range(255));
      if (t == cfp_pkg::TECH_SOUNDING) t = 8'h02;
      push_block(t, 8'($urandom_range(2, 8)), 8'($urandom_range(255)));
    end
    if (with_sounding) push_block(cfp_pkg::TECH_SOUNDING, 8'($urandom_range(9, 14)), pick_mask());
    repeat ($urandom_range(3)) frame.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void make_random_frame();
    int roll;
    int n;
    roll = $urandom_range(99);
    if (roll < 65) begin
      build_good($urandom_range(9) != 0);
    end else if (roll < 80) begin
      build_good(1'b1);
      frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
    end else if (roll < 90) begin
      build_good(1'b1);
      n = $urandom_range(1, frame.size());
      frame = frame[0:n-1];
    end else begin
      frame = {};
      repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) frame[0] = cfp_pkg::HEADER_BYTE;
    end
  endfunction

  initial begin
    int frames_sent;
    frames_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    frame = '{8'hff};
    send_frame();
    frame = '{8'h00, cfp_pkg::HEADER_BYTE, 8'h02, 8'h00};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'h02};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'hfd, 8'hff};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'h02, 8'h00};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'h02, 8'h00, 8'h05};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'h02, 8'h00, 8'h05, 8'h01};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'h02, 8'h00,
              cfp_pkg::TECH_SOUNDING, 8'h08};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'h02, 8'h00,
              cfp_pkg::TECH_SOUNDING, 8'h09, 8'h1f};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'hff, 8'hff,
              cfp_pkg::TECH_SOUNDING, 8'h09, 8'he0,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    frame = '{cfp_pkg::HEADER_BYTE, cfp_pkg::HEADER_BYTE, 8'h02, 8'h00, 8'h02, 8'h02,
              cfp_pkg::TECH_SOUNDING, 8'h09,
              8'h1f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    send_frame();

    while (items_counted < RANDOM_ITEMS) begin
      calm = (frames_sent >= 20 && frames_sent < 32);
      if (frames_sent == 5) hold_req = 1'b1;
      make_random_frame();
      send_frame();
      frames_sent++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(status, security_level);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && $urandom_range(99) < IDLE_PCT;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cfp_pkg.sv
rtl/capability_frame_parser_core.sv
dv/tb_capability_frame_parser_core.sv
